@@ hw/rtl/cdsd_pkg.sv @@
// Package with the segment table, divider constants and digit types of the countdown display.
package cdsd_pkg;

  localparam int unsigned CountWidth  = 16;
  localparam int unsigned ShownWidth  = 11;
  localparam int unsigned TensWidth   = 7;
  localparam int unsigned DigitWidth  = 4;
  localparam int unsigned SegWidth    = 8;

  localparam logic [0:0] OP_TICK = 1'b0;
  localparam logic [0:0] OP_LOAD = 1'b1;

  // Counts above this value are shown in minutes.
  localparam logic [CountWidth-1:0] SECONDS_SHOWN_MAX = 16'd99;

  // Reciprocal of 60 scaled by 2^22, rounded up; exact for every 16-bit count.
  localparam logic [16:0] DIV60_MULT  = 17'd69906;
  localparam int unsigned DIV60_SHIFT = 22;

  // Reciprocal of 10 scaled by 2^16, rounded up; exact for every shown value.
  localparam logic [12:0] DIV10_MULT  = 13'd6554;
  localparam int unsigned DIV10_SHIFT = 16;

  localparam logic [TensWidth-1:0] TENS_MAX = 7'd9;

  localparam logic [SegWidth-1:0] SEG_ZERO = 8'h5F;

  typedef struct packed {
    logic [DigitWidth-1:0] units;
    logic [DigitWidth-1:0] tens;
    logic                  tens_over;
  } digits_t;

  // Segment pattern for a decimal digit; six and seven share a pattern.
  function automatic logic [SegWidth-1:0] seg_pattern(input logic [DigitWidth-1:0] digit);
    logic [SegWidth-1:0] pattern;
    case (digit)
      4'd0: pattern = 8'h5F;
      4'd1: pattern = 8'h0C;
      4'd2: pattern = 8'h9B;
      4'd3: pattern = 8'h9E;
      4'd4: pattern = 8'hCC;
      4'd5: pattern = 8'hD6;
      4'd6: pattern = 8'h9F;
      4'd7: pattern = 8'h9F;
      4'd8: pattern = 8'hDF;
      4'd9: pattern = 8'hDC;
      default: pattern = SEG_ZERO;
    endcase
    return pattern;
  endfunction

endpackage

@@ hw/rtl/cdsd_split.sv @@
// Splits the shown value into units and tens digits and flags a tens digit above nine.
module cdsd_split (
  input  logic [cdsd_pkg::ShownWidth-1:0] shown,
  output cdsd_pkg::digits_t               digits
);
  import cdsd_pkg::*;

  logic [23:0]            prod10;
  logic [TensWidth-1:0]   tens;
  logic [ShownWidth-1:0]  rem;

  // Multiply by the scaled reciprocal of ten; the quotient needs at most seven bits.
  assign prod10 = 24'(shown) * 24'(DIV10_MULT);
  assign tens   = prod10[DIV10_SHIFT +: TensWidth];
  assign rem    = shown - ShownWidth'(11'(tens) * 11'd10);

  assign digits.units     = rem[DigitWidth-1:0];
  assign digits.tens      = tens[DigitWidth-1:0];
  assign digits.tens_over = (tens > TENS_MAX);

endmodule

@@ hw/rtl/countdown_two_digit_segment_display_top.sv @@
// Top level of the two-digit seven-segment seconds countdown.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | input     | in_valid / in_stall   | opcode, start_value
//   out     | output    | out_valid / out_stall | units_segments, tens_segments,
//           |           |                       | seconds_left, finished, digit_overflow
//
// One item is taken every cycle while the output is not stalled, and each passes
// through the four register stages: input register, count update, minutes
// conversion (one multiply), digit split with segment lookup.
// Reset (rst, synchronous) empties every stage, clears the count and the running
// flag, and sets both stored patterns to the pattern for zero.
// A stall on the output freezes all stages at once; the input is stalled only while
// a finished result waits in the output register and is not taken.
module countdown_two_digit_segment_display_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [0:0]                        opcode,
  input  logic [cdsd_pkg::CountWidth-1:0]   start_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cdsd_pkg::SegWidth-1:0]     units_segments,
  output logic [cdsd_pkg::SegWidth-1:0]     tens_segments,
  output logic [cdsd_pkg::CountWidth-1:0]   seconds_left,
  output logic                              finished,
  output logic                              digit_overflow
);
  import cdsd_pkg::*;

  // The whole pipeline moves when the output register is free or being emptied.
  logic advance;
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  // Stage 1: input register.
  logic                  s1_valid;
  logic [0:0]            s1_opcode;
  logic [CountWidth-1:0] s1_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
    if (advance && in_valid) begin
      s1_opcode <= opcode;
      s1_start  <= start_value;
    end
  end

  // Stage 2: the count and running flag are the state carried from item to item.
  // A load sets the count and runs if nonzero; a tick while running lowers it by
  // one and stops at zero; a tick while idle changes nothing and shows nothing.
  logic [CountWidth-1:0] count_value;
  logic                  running_flag;
  logic [CountWidth-1:0] count_value_next;
  logic                  running_flag_next;
  logic                  show_next;
  logic [CountWidth-1:0] count_minus;

  assign count_minus = count_value - 16'd1;

  always_comb begin
    count_value_next  = count_value;
    running_flag_next = running_flag;
    show_next         = 1'b0;
    if (s1_opcode == OP_LOAD) begin
      count_value_next  = s1_start;
      running_flag_next = (s1_start != '0);
      show_next         = 1'b1;
    end else if (running_flag) begin
      count_value_next  = count_minus;
      running_flag_next = (count_minus != '0);
      show_next         = 1'b1;
    end
  end

  logic                  s2_valid;
  logic [CountWidth-1:0] s2_count;
  logic                  s2_show;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid     <= 1'b0;
      count_value  <= '0;
      running_flag <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
      if (s1_valid) begin
        count_value  <= count_value_next;
        running_flag <= running_flag_next;
      end
    end
    if (advance && s1_valid) begin
      s2_count <= count_value_next;
      s2_show  <= show_next;
    end
  end

  // Stage 3: the shown value is the count itself, or whole minutes plus one when
  // the count is above 99. Division by 60 is a multiply by the scaled reciprocal.
  logic [32:0]           prod60;
  logic [ShownWidth-1:0] shown_next;

  assign prod60 = 33'(s2_count) * 33'(DIV60_MULT);

  always_comb begin
    if (s2_count > SECONDS_SHOWN_MAX) begin
      shown_next = prod60[DIV60_SHIFT +: ShownWidth] + 11'd1;
    end else begin
      shown_next = s2_count[ShownWidth-1:0];
    end
  end

  logic                  s3_valid;
  logic [CountWidth-1:0] s3_count;
  logic                  s3_show;
  logic [ShownWidth-1:0] s3_shown;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
    if (advance && s2_valid) begin
      s3_count <= s2_count;
      s3_show  <= s2_show;
      s3_shown <= shown_next;
    end
  end

  // Stage 4: split into digits and look up the patterns. A tens digit above nine
  // keeps the stored tens pattern and raises the overflow flag; units still update.
  digits_t digits;

  cdsd_split u_split (
    .shown  (s3_shown),
    .digits (digits)
  );

  logic [SegWidth-1:0] units_pattern;
  logic [SegWidth-1:0] tens_pattern;
  logic [SegWidth-1:0] units_pattern_next;
  logic [SegWidth-1:0] tens_pattern_next;
  logic                over_next;

  always_comb begin
    units_pattern_next = units_pattern;
    tens_pattern_next  = tens_pattern;
    over_next          = 1'b0;
    if (s3_show) begin
      units_pattern_next = seg_pattern(digits.units);
      if (digits.tens_over) begin
        over_next = 1'b1;
      end else begin
        tens_pattern_next = seg_pattern(digits.tens);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      units_pattern <= SEG_ZERO;
      tens_pattern  <= SEG_ZERO;
    end else if (advance) begin
      out_valid <= s3_valid;
      if (s3_valid) begin
        units_pattern <= units_pattern_next;
        tens_pattern  <= tens_pattern_next;
      end
    end
    if (advance && s3_valid) begin
      units_segments <= units_pattern_next;
      tens_segments  <= tens_pattern_next;
      seconds_left   <= s3_count;
      finished       <= (s3_count == '0);
      digit_overflow <= over_next;
    end
  end

endmodule

@@ hw/rtl/cdsd_checker.sv @@
// Port-level checker for the countdown display, bound to the top level.
module cdsd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [cdsd_pkg::SegWidth-1:0]   units_segments,
  input logic [cdsd_pkg::SegWidth-1:0]   tens_segments,
  input logic [cdsd_pkg::CountWidth-1:0] seconds_left,
  input logic                            finished,
  input logic                            digit_overflow
);
  import cdsd_pkg::*;

  // A waiting result must hold while it is stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(seconds_left) &&
      $stable(units_segments) && $stable(tens_segments)))
    else $error("result changed while stalled");

  // The done flag follows the count.
  a_finished: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (finished == (seconds_left == '0)))
    else $error("finished does not match a zero count");

  // Only counts of 5940 and more give a shown value with a tens digit above nine.
  a_overflow_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && digit_overflow) |-> (seconds_left >= 16'd5940))
    else $error("tens overflow at a small count");

  // A zero count always shows zero on both digits.
  a_zero_shown: assert property (@(posedge clk) disable iff (rst)
    (out_valid && seconds_left == '0) |->
      (units_segments == SEG_ZERO && tens_segments == SEG_ZERO))
    else $error("zero count not shown as zero");

endmodule

bind countdown_two_digit_segment_display_top cdsd_checker u_cdsd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .units_segments (units_segments),
  .tens_segments  (tens_segments),
  .seconds_left   (seconds_left),
  .finished       (finished),
  .digit_overflow (digit_overflow)
);
